>>> rtl/bmp565_pkg.sv
// Shared types and constants for the BMP 24-bit to RGB565 pixel stream block.
// Used by the parser, the output stage and the top level; depends on nothing.
`default_nettype none

package bmp565_pkg;

  localparam int HEADER_BYTES = 54;

  localparam logic [5:0] HDR_OFS0 = 6'd10;
  localparam logic [5:0] HDR_W0   = 6'd18;
  localparam logic [5:0] HDR_H0   = 6'd22;
  localparam logic [5:0] HDR_BPP0 = 6'd28;
  localparam logic [5:0] HDR_CMP0 = 6'd30;
  localparam logic [5:0] HDR_LAST = 6'(HEADER_BYTES - 1);

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_IDLE,
    PH_DONE_PENDING
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_DONE,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NOT_BMP,
    ERR_FORMAT,
    ERR_ROW_WIDE,
    ERR_TRUNCATED
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    err_t        error_code;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/bmp565_parse.sv
// Byte-wise BMP parser: header capture and checks, offset skip, row walk and RGB565 packing.
// Uses bmp565_pkg; produces at most one result per accepted byte.
`default_nettype none

module bmp565_parse #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 160,
  parameter int ROW_BYTES_MAX = 512
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     byte_fire,
  input  wire [7:0]               data_byte,
  input  wire                     start_of_file,
  input  wire                     end_of_file,
  input  wire [7:0]               x_origin,
  input  wire [7:0]               y_origin,
  output logic                    res_valid,
  output bmp565_pkg::result_t     res
);

  localparam int ROW_W = $clog2(ROW_BYTES_MAX + 1);
  localparam int SUM_W = ((ROW_W > 8) ? ROW_W : 8) + 1;

  bmp565_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic               sig_bad_r, sig_bad_nxt;
  logic [31:0]        offset_r, offset_nxt;
  logic [31:0]        width_r, width_nxt;
  logic [31:0]        height_r, height_nxt;
  logic [15:0]        bpp_r, bpp_nxt;
  logic [31:0]        comp_r, comp_nxt;
  logic [33:0]        row_calc_r, row_calc_nxt;
  logic [31:0]        hmag_r, hmag_nxt;
  logic [31:0]        ds_r, ds_nxt;
  logic [ROW_W-1:0]   row_bytes_r, row_bytes_nxt;
  logic [ROW_W-1:0]   pix_bytes_r, pix_bytes_nxt;
  logic [ROW_W-1:0]   byte_in_row_r, byte_in_row_nxt;
  logic [ROW_W-1:0]   col_r, col_nxt;
  logic [1:0]         tri_r, tri_nxt;
  logic [31:0]        rows_left_r, rows_left_nxt;
  logic [31:0]        ofs_r, ofs_nxt;
  logic               top_down_r, top_down_nxt;
  logic [7:0]         red_r, red_nxt;
  logic [7:0]         green_r, green_nxt;

  bmp565_pkg::phase_t  ph;
  bmp565_pkg::result_t rres;
  bmp565_pkg::result_t done_res;
  logic                rv;
  logic                pend;
  logic                drew;
  logic [31:0]         pos;
  logic [5:0]          hpos;
  logic [31:0]         wmag;
  logic [33:0]         rs;
  logic [33:0]         pix3;
  logic [SUM_W-1:0]    xsum;
  logic [8:0]          ysum;
  logic                vis;
  logic [ROW_W-1:0]    bir_inc;
  logic                row_end;

  function automatic bmp565_pkg::result_t err_res(input bmp565_pkg::err_t code);
    bmp565_pkg::result_t r;
    r = '0;
    r.kind = bmp565_pkg::KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  always_comb begin
    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    sig_bad_nxt     = sig_bad_r;
    offset_nxt      = offset_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    bpp_nxt         = bpp_r;
    comp_nxt        = comp_r;
    row_calc_nxt    = row_calc_r;
    hmag_nxt        = hmag_r;
    ds_nxt          = ds_r;
    row_bytes_nxt   = row_bytes_r;
    pix_bytes_nxt   = pix_bytes_r;
    byte_in_row_nxt = byte_in_row_r;
    col_nxt         = col_r;
    tri_nxt         = tri_r;
    rows_left_nxt   = rows_left_r;
    ofs_nxt         = ofs_r;
    top_down_nxt    = top_down_r;
    red_nxt         = red_r;
    green_nxt       = green_r;

    done_res      = '0;
    done_res.kind = bmp565_pkg::KIND_DONE;
    rres = '0;
    rv   = 1'b0;
    pend = 1'b0;
    drew = 1'b0;
    ph   = phase_r;
    pos  = pos_r;
    hpos = pos_r[5:0];

    wmag    = width_r[31] ? (32'd0 - width_r) : width_r;
    rs      = {row_calc_r[33:2], 2'b00};
    pix3    = row_calc_r - 34'd3;
    xsum    = SUM_W'(x_origin) + SUM_W'(col_r);
    ysum    = {1'b0, y_origin} + {1'b0, ofs_r[7:0]};
    vis     = (xsum < SUM_W'(SCREEN_WIDTH)) && (ofs_r[31:8] == 24'd0) &&
              (ysum < 9'(SCREEN_HEIGHT));
    bir_inc = byte_in_row_r + ROW_W'(1);
    row_end = (bir_inc == row_bytes_r);

    if (byte_fire) begin
      if (phase_r == bmp565_pkg::PH_DONE_PENDING) begin
        pend = 1'b1;
        ph   = bmp565_pkg::PH_IDLE;
      end
      if (start_of_file) begin
        ph  = bmp565_pkg::PH_HEADER;
        pos = 32'd0;
      end
      hpos      = pos[5:0];
      phase_nxt = ph;

      case (ph)
        bmp565_pkg::PH_HEADER: begin
          case (hpos)
            6'd0:                           sig_bad_nxt = (data_byte != bmp565_pkg::SIG_B);
            6'd1:                           sig_bad_nxt = sig_bad_r |
                                                          (data_byte != bmp565_pkg::SIG_M);
            bmp565_pkg::HDR_OFS0:           offset_nxt[7:0]   = data_byte;
            bmp565_pkg::HDR_OFS0 + 6'd1:    offset_nxt[15:8]  = data_byte;
            bmp565_pkg::HDR_OFS0 + 6'd2:    offset_nxt[23:16] = data_byte;
            bmp565_pkg::HDR_OFS0 + 6'd3:    offset_nxt[31:24] = data_byte;
            bmp565_pkg::HDR_W0:             width_nxt[7:0]    = data_byte;
            bmp565_pkg::HDR_W0 + 6'd1:      width_nxt[15:8]   = data_byte;
            bmp565_pkg::HDR_W0 + 6'd2:      width_nxt[23:16]  = data_byte;
            bmp565_pkg::HDR_W0 + 6'd3:      width_nxt[31:24]  = data_byte;
            bmp565_pkg::HDR_H0:             height_nxt[7:0]   = data_byte;
            bmp565_pkg::HDR_H0 + 6'd1:      height_nxt[15:8]  = data_byte;
            bmp565_pkg::HDR_H0 + 6'd2:      height_nxt[23:16] = data_byte;
            bmp565_pkg::HDR_H0 + 6'd3:      height_nxt[31:24] = data_byte;
            bmp565_pkg::HDR_BPP0: begin
              bpp_nxt[7:0] = data_byte;
              // Width, height and offset are complete here; size them ahead of the checks.
              row_calc_nxt = {2'b00, wmag} + {1'b0, wmag, 1'b0} + 34'd3;
              hmag_nxt     = height_r[31] ? (32'd0 - height_r) : height_r;
              ds_nxt       = (offset_r < 32'(bmp565_pkg::HEADER_BYTES)) ?
                             32'(bmp565_pkg::HEADER_BYTES) : offset_r;
            end
            bmp565_pkg::HDR_BPP0 + 6'd1:    bpp_nxt[15:8]     = data_byte;
            bmp565_pkg::HDR_CMP0:           comp_nxt[7:0]     = data_byte;
            bmp565_pkg::HDR_CMP0 + 6'd1:    comp_nxt[15:8]    = data_byte;
            bmp565_pkg::HDR_CMP0 + 6'd2:    comp_nxt[23:16]   = data_byte;
            bmp565_pkg::HDR_CMP0 + 6'd3:    comp_nxt[31:24]   = data_byte;
            default: ;
          endcase

          if (hpos != bmp565_pkg::HDR_LAST) begin
            if (end_of_file) begin
              rv = 1'b1;
              rres = err_res(bmp565_pkg::ERR_TRUNCATED);
              phase_nxt = bmp565_pkg::PH_IDLE;
            end
          end else if (sig_bad_r) begin
            rv = 1'b1;
            rres = err_res(bmp565_pkg::ERR_NOT_BMP);
            phase_nxt = bmp565_pkg::PH_IDLE;
          end else if ((bpp_r != 16'd24) || (comp_r != 32'd0)) begin
            rv = 1'b1;
            rres = err_res(bmp565_pkg::ERR_FORMAT);
            phase_nxt = bmp565_pkg::PH_IDLE;
          end else if (rs > 34'(ROW_BYTES_MAX)) begin
            rv = 1'b1;
            rres = err_res(bmp565_pkg::ERR_ROW_WIDE);
            phase_nxt = bmp565_pkg::PH_IDLE;
          end else if ((rs == 34'd0) || (hmag_r == 32'd0)) begin
            rv = 1'b1;
            rres = done_res;
            phase_nxt = bmp565_pkg::PH_IDLE;
          end else begin
            row_bytes_nxt   = rs[ROW_W-1:0];
            pix_bytes_nxt   = pix3[ROW_W-1:0];
            byte_in_row_nxt = '0;
            col_nxt         = '0;
            tri_nxt         = 2'd0;
            rows_left_nxt   = hmag_r;
            top_down_nxt    = height_r[31];
            ofs_nxt         = height_r[31] ? 32'd0 : (hmag_r - 32'd1);
            phase_nxt       = (ds_r > 32'(bmp565_pkg::HEADER_BYTES)) ?
                              bmp565_pkg::PH_SKIP : bmp565_pkg::PH_PIXELS;
            if (end_of_file) begin
              rv = 1'b1;
              rres = err_res(bmp565_pkg::ERR_TRUNCATED);
              phase_nxt = bmp565_pkg::PH_IDLE;
            end
          end
        end

        bmp565_pkg::PH_SKIP: begin
          if (({1'b0, pos} + 33'd1) >= {1'b0, ds_r}) begin
            phase_nxt = bmp565_pkg::PH_PIXELS;
          end
          if (end_of_file) begin
            rv = 1'b1;
            rres = err_res(bmp565_pkg::ERR_TRUNCATED);
            phase_nxt = bmp565_pkg::PH_IDLE;
          end
        end

        bmp565_pkg::PH_PIXELS: begin
          if (byte_in_row_r < pix_bytes_r) begin
            case (tri_r)
              2'd0: begin
                red_nxt = data_byte;
                tri_nxt = 2'd1;
              end
              2'd1: begin
                green_nxt = data_byte;
                tri_nxt   = 2'd2;
              end
              default: begin
                tri_nxt = 2'd0;
                col_nxt = col_r + ROW_W'(1);
                drew    = vis;
              end
            endcase
          end
          byte_in_row_nxt = bir_inc;
          if (row_end) begin
            byte_in_row_nxt = '0;
            col_nxt         = '0;
            tri_nxt         = 2'd0;
            rows_left_nxt   = rows_left_r - 32'd1;
            ofs_nxt         = top_down_r ? (ofs_r + 32'd1) : (ofs_r - 32'd1);
          end

          if (row_end && (rows_left_r == 32'd1)) begin
            rv = 1'b1;
            if (drew) begin
              phase_nxt = bmp565_pkg::PH_DONE_PENDING;
            end else begin
              rres = done_res;
              phase_nxt = bmp565_pkg::PH_IDLE;
            end
          end else if (end_of_file) begin
            rv = 1'b1;
            rres = err_res(bmp565_pkg::ERR_TRUNCATED);
            phase_nxt = bmp565_pkg::PH_IDLE;
          end else if (drew) begin
            rv = 1'b1;
          end
          if (drew && (rres.kind == bmp565_pkg::KIND_PIXEL)) begin
            rres.pixel_x     = xsum[6:0];
            rres.pixel_y     = ysum[7:0];
            rres.pixel_color = {red_r[7:3], green_r[7:2], data_byte[7:3]};
          end
        end

        default: ;
      endcase

      if ((ph == bmp565_pkg::PH_HEADER) || (ph == bmp565_pkg::PH_SKIP) ||
          (ph == bmp565_pkg::PH_PIXELS)) begin
        pos_nxt = (pos == 32'hFFFF_FFFF) ? pos : (pos + 32'd1);
      end
    end

    res_valid = byte_fire && (pend || rv);
    res       = pend ? done_res : rres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bmp565_pkg::PH_HEADER;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sig_bad_r     <= sig_bad_nxt;
    offset_r      <= offset_nxt;
    width_r       <= width_nxt;
    height_r      <= height_nxt;
    bpp_r         <= bpp_nxt;
    comp_r        <= comp_nxt;
    row_calc_r    <= row_calc_nxt;
    hmag_r        <= hmag_nxt;
    ds_r          <= ds_nxt;
    row_bytes_r   <= row_bytes_nxt;
    pix_bytes_r   <= pix_bytes_nxt;
    byte_in_row_r <= byte_in_row_nxt;
    col_r         <= col_nxt;
    tri_r         <= tri_nxt;
    rows_left_r   <= rows_left_nxt;
    ofs_r         <= ofs_nxt;
    top_down_r    <= top_down_nxt;
    red_r         <= red_nxt;
    green_r       <= green_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/bmp565_skid.sv
// Result output register with one skid entry, so the parser keeps taking bytes
// while a result waits. Uses bmp565_pkg for the result word type.
`default_nettype none

module bmp565_skid (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  bmp565_pkg::result_t  push_data,
  output logic                 ready,
  output logic                 out_valid,
  output bmp565_pkg::result_t  out_data,
  input  wire                  out_ready
);

  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  bmp565_pkg::result_t main_r, main_nxt;
  bmp565_pkg::result_t skid_r, skid_nxt;
  logic                pop;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    pop            = main_valid_r && out_ready;

    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign ready     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

`default_nettype wire

>>> rtl/bmp24_stream_to_rgb565_pixels.sv
// Top level: BMP 24-bit byte stream in, RGB565 pixel writes, done and error words out.
// Depends on bmp565_pkg, bmp565_parse and bmp565_skid.
//
// Usage: feed the file one byte per word on the in_ channel; in_tuser marks the
// first byte of a file and restarts the parser, in_tlast marks the last byte.
// Each byte yields zero or one result word on the out_ channel: a pixel write at
// its screen position, an image done word, or an error word with its code.
// Pixels are placed at the x and y origin registers and clipped to the screen size.
// The user must write them through the cfg_ port only while no result is outstanding;
// the block does not enforce this. Throughput: one byte per cycle while in_tready is
// high; all per-byte work sits between the parser state registers and the result
// register.
// When the receiver stalls, one further result is held in a skid entry and
// in_tready drops only while both the result register and skid entry are full.
// Reset, synchronous and active low, returns the parser to the header, clears
// both origin registers to zero and empties the output stage.
`default_nettype none

module bmp24_stream_to_rgb565_pixels #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 160,
  parameter int ROW_BYTES_MAX = 512
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [7:0]                          in_tdata,   // data_byte
  input  wire                                 in_tuser,   // start_of_file
  input  wire                                 in_tlast,   // end_of_file
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // pixel_x[6:0], pixel_y[14:7], pixel_color[30:15], error_code[32:31], zero fill
  output logic [39:0]                         out_tdata,
  output logic [1:0]                          out_tuser,  // result_kind
  input  wire                                 cfg_wr_en,
  input  wire  [bmp565_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [7:0]                          cfg_wdata
);

  logic [7:0]          x_origin_r;
  logic [7:0]          y_origin_r;
  logic                byte_fire;
  logic                res_valid;
  bmp565_pkg::result_t res;
  bmp565_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= 8'd0;
      y_origin_r <= 8'd0;
    end else if (cfg_wr_en) begin
      if (cfg_index == bmp565_pkg::REG_X_ORIGIN) begin
        x_origin_r <= cfg_wdata;
      end
      if (cfg_index == bmp565_pkg::REG_Y_ORIGIN) begin
        y_origin_r <= cfg_wdata;
      end
    end
  end

  assign byte_fire = in_tvalid && in_tready;

  bmp565_parse #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ROW_BYTES_MAX (ROW_BYTES_MAX)
  ) u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_fire     (byte_fire),
    .data_byte     (in_tdata),
    .start_of_file (in_tuser),
    .end_of_file   (in_tlast),
    .x_origin      (x_origin_r),
    .y_origin      (y_origin_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  bmp565_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_data  (out_res),
    .out_ready (out_tready)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {7'd0, out_res.error_code, out_res.pixel_color,
                      out_res.pixel_y, out_res.pixel_x};

`ifndef SYNTHESIS
  a_pixel_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == bmp565_pkg::KIND_PIXEL)) |->
      (out_tdata[14:7] < 8'(SCREEN_HEIGHT)))
    else $error("pixel write below the screen");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != bmp565_pkg::KIND_ERROR)) |-> (out_tdata[32:31] == 2'b00))
    else $error("error code set on a non-error word");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_bmp24_stream_to_rgb565_pixels.sv
`timescale 1ns / 100ps
// Self-checking testbench for bmp24_stream_to_rgb565_pixels: streams directed and random BMP files
// through the byte channel and compares each result word with a built-in predictor of the parser.
// Depends on bmp565_pkg and the top level RTL only.
module tb_bmp24_stream_to_rgb565_pixels;
  import bmp565_pkg::*;

  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 160;
  localparam int ROW_MAX     = 512;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_LIMIT = 5000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic [1:0]           out_tuser;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [7:0]           cfg_wdata  = '0;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int mismatches  = 0;
  int cycle_count = 0;

  // Predictor copy of the origin registers and the parser state.
  logic [7:0]  x_org, y_org;
  logic [31:0] byte_pos, img_w, img_h, comp_mode, data_ofs, row_idx;
  logic [15:0] bpp, held_rg;
  logic [9:0]  row_byte;
  bit          sig_bad;
  phase_t      phase;

  bit          word_out;
  result_t     word_next;
  result_t     results_due[$];
  logic [7:0]  file_bytes[$];

  bmp24_stream_to_rgb565_pixels #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .ROW_BYTES_MAX(ROW_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at cycle %0d, %s: got %0h, expected %0h", cycle_count, what, got, want);
    end
  endtask

  function automatic logic [31:0] magnitude(input logic [31:0] raw);
    return raw[31] ? -raw : raw;
  endfunction

  function automatic longint unsigned row_bytes(input logic [15:0] bits, input logic [31:0] w);
    longint unsigned a, b;
    a = bits;
    b = magnitude(w);
    return ((a * b + 31) / 32) * 4;
  endfunction

  function automatic longint unsigned pixel_start();
    return (data_ofs < HEADER_BYTES) ? HEADER_BYTES : data_ofs;
  endfunction

  function automatic void clear_parser();
    byte_pos  = '0;
    img_w     = '0;
    img_h     = '0;
    bpp       = '0;
    comp_mode = '0;
    data_ofs  = '0;
    row_idx   = '0;
    row_byte  = '0;
    held_rg   = '0;
    sig_bad   = 1'b0;
    phase     = PH_HEADER;
  endfunction

  function automatic void post_result(input kind_t kind, input logic [6:0] x, input logic [7:0] y,
                                      input logic [15:0] color, input err_t code);
    if (!word_out) begin
      word_out              = 1'b1;
      word_next.kind        = kind;
      word_next.pixel_x     = x;
      word_next.pixel_y     = y;
      word_next.pixel_color = color;
      word_next.error_code  = code;
    end
  endfunction

  function automatic void give_error(input err_t code);
    post_result(KIND_ERROR, '0, '0, '0, code);
    phase = PH_IDLE;
  endfunction

  function automatic void take_header_byte(input logic [31:0] pos, input logic [7:0] b,
                                           input bit eof);
    logic [31:0] wide_b;
    longint unsigned rs;
    wide_b = {24'd0, b};
    if (pos == 0 && b != SIG_B) sig_bad = 1'b1;
    if (pos == 1 && b != SIG_M) sig_bad = 1'b1;
    if (pos >= HDR_OFS0 && pos <= HDR_OFS0 + 3) data_ofs |= wide_b << (8 * (pos - HDR_OFS0));
    if (pos >= HDR_W0 && pos <= HDR_W0 + 3) img_w |= wide_b << (8 * (pos - HDR_W0));
    if (pos >= HDR_H0 && pos <= HDR_H0 + 3) img_h |= wide_b << (8 * (pos - HDR_H0));
    if (pos >= HDR_BPP0 && pos <= HDR_BPP0 + 1) bpp |= 16'(wide_b << (8 * (pos - HDR_BPP0)));
    if (pos >= HDR_CMP0 && pos <= HDR_CMP0 + 3) comp_mode |= wide_b << (8 * (pos - HDR_CMP0));
    if (pos < HDR_LAST) begin
      if (eof) give_error(ERR_TRUNCATED);
      return;
    end
    if (sig_bad) begin
      give_error(ERR_NOT_BMP);
      return;
    end
    if (bpp != 16'd24 || comp_mode != 0) begin
      give_error(ERR_FORMAT);
      return;
    end
    rs = row_bytes(bpp, img_w);
    if (rs > ROW_MAX) begin
      give_error(ERR_ROW_WIDE);
      return;
    end
    if (rs == 0 || magnitude(img_h) == 0) begin
      post_result(KIND_DONE, '0, '0, '0, ERR_NOT_BMP);
      phase = PH_IDLE;
      return;
    end
    row_idx  = '0;
    row_byte = '0;
    phase    = (pixel_start() > HEADER_BYTES) ? PH_SKIP : PH_PIXELS;
    if (eof) give_error(ERR_TRUNCATED);
  endfunction

  function automatic void take_pixel_byte(input logic [7:0] b, input bit eof);
    longint unsigned wid, hgt, rs, k, col, ofs, yy, xx;
    bit drew;
    logic [6:0] px;
    logic [7:0] py;
    logic [15:0] color;
    wid   = magnitude(img_w);
    hgt   = magnitude(img_h);
    rs    = row_bytes(bpp, img_w);
    k     = row_byte;
    drew  = 1'b0;
    px    = '0;
    py    = '0;
    color = '0;
    if (k < 3 * wid) begin
      if (k % 3 == 0) begin
        held_rg[15:8] = b;
      end else if (k % 3 == 1) begin
        held_rg[7:0] = b;
      end else begin
        col = k / 3;
        ofs = img_h[31] ? row_idx : hgt - 1 - row_idx;
        yy  = y_org + ofs;
        xx  = x_org + col;
        if (yy < SCREEN_H && xx < SCREEN_W) begin
          color = {held_rg[15:11], held_rg[7:2], b[7:3]};
          px    = xx[6:0];
          py    = yy[7:0];
          drew  = 1'b1;
        end
      end
    end
    k++;
    if (k >= rs) begin
      k = 0;
      row_idx++;
    end
    row_byte = k[9:0];
    if (row_idx >= hgt) begin
      if (drew) begin
        post_result(KIND_PIXEL, px, py, color, ERR_NOT_BMP);
        phase = PH_DONE_PENDING;
      end else begin
        post_result(KIND_DONE, '0, '0, '0, ERR_NOT_BMP);
        phase = PH_IDLE;
      end
      return;
    end
    if (eof) begin
      give_error(ERR_TRUNCATED);
      return;
    end
    if (drew) post_result(KIND_PIXEL, px, py, color, ERR_NOT_BMP);
  endfunction

  function automatic void predict_word(input logic [7:0] b, input bit sof, input bit eof);
    bit parsing;
    word_out = 1'b0;
    if (phase == PH_DONE_PENDING) begin
      post_result(KIND_DONE, '0, '0, '0, ERR_NOT_BMP);
      phase = PH_IDLE;
    end
    if (sof) clear_parser();
    parsing = (phase == PH_HEADER || phase == PH_SKIP || phase == PH_PIXELS);
    if (phase == PH_HEADER) begin
      take_header_byte(byte_pos, b, eof);
    end else if (phase == PH_SKIP) begin
      if ({32'd0, byte_pos} + 1 >= pixel_start()) phase = PH_PIXELS;
      if (eof) give_error(ERR_TRUNCATED);
    end else if (phase == PH_PIXELS) begin
      take_pixel_byte(b, eof);
    end
    if (parsing && byte_pos != '1) byte_pos++;
    if (word_out) results_due.push_back(word_next);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result word with none expected", {30'd0, out_tuser}, '0);
      end else begin
        want = results_due.pop_front();
        if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[6:0] !== want.pixel_x) report_mismatch("x", out_tdata[6:0], want.pixel_x);
        if (out_tdata[14:7] !== want.pixel_y) report_mismatch("y", out_tdata[14:7], want.pixel_y);
        if (out_tdata[30:15] !== want.pixel_color) begin
          report_mismatch("color", out_tdata[30:15], want.pixel_color);
        end
        if (out_tdata[32:31] !== want.error_code) begin
          report_mismatch("error code", out_tdata[32:31], want.error_code);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_word(input logic [7:0] b, input bit sof, input bit eof);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sof;
    in_tlast  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(b, sof, eof);
  endtask

  task automatic send_file(input bit mark_eof);
    int last;
    last = file_bytes.size() - 1;
    for (int i = 0; i <= last; i++) send_word(file_bytes[i], i == 0, mark_eof && i == last);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (results_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (results_due.size() != 0) begin
      report_mismatch("results never arrived", results_due.size(), '0);
      results_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_origin(input logic [7:0] x, input logic [7:0] y);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_X_ORIGIN;
    cfg_wdata <= x;
    @(posedge clk);
    x_org = x;
    cfg_index <= REG_Y_ORIGIN;
    cfg_wdata <= y;
    @(posedge clk);
    y_org = y;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void build_file(input logic [31:0] w, input logic [31:0] h,
                                     input logic [15:0] bits, input logic [31:0] comp,
                                     input logic [31:0] ofs, input int data_len);
    file_bytes.delete();
    for (int i = 0; i < HEADER_BYTES; i++) file_bytes.push_back(8'($urandom));
    file_bytes[0] = SIG_B;
    file_bytes[1] = SIG_M;
    for (int i = 0; i < 4; i++) begin
      file_bytes[HDR_OFS0 + i] = ofs[8*i +: 8];
      file_bytes[HDR_W0 + i]   = w[8*i +: 8];
      file_bytes[HDR_H0 + i]   = h[8*i +: 8];
      file_bytes[HDR_CMP0 + i] = comp[8*i +: 8];
    end
    file_bytes[HDR_BPP0]     = bits[7:0];
    file_bytes[HDR_BPP0 + 1] = bits[15:8];
    for (int i = HEADER_BYTES; i < int'(ofs); i++) file_bytes.push_back(8'($urandom));
    for (int i = 0; i < data_len; i++) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic int image_bytes(input logic [31:0] w, input logic [31:0] h);
    return int'(row_bytes(16'd24, w) * magnitude(h));
  endfunction

  function automatic void trim_file(input int keep);
    while (file_bytes.size() > keep) void'(file_bytes.pop_back());
  endfunction

  function automatic logic [7:0] pick_origin(input int screen);
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'(screen - 1 - $urandom_range(7));
      3:       return 8'(screen + $urandom_range(255 - screen));
      default: return 8'($urandom_range(screen - 1));
    endcase
  endfunction

  task automatic test_header_checks();
    build_file(4, 2, 24, 0, 54, 0);
    file_bytes[0] = 8'h41;
    send_file(1);
    build_file(4, 2, 16, 0, 54, 0);
    send_file(1);
    build_file(171, 1, 24, 0, 54, 0);
    send_file(1);
    build_file(4, 2, 24, 0, 54, 0);
    trim_file(20);
    send_file(1);
    settle();
  endtask

  task automatic test_empty_images();
    build_file(0, 5, 24, 0, 54, 0);
    send_file(1);
    settle();
  endtask

  task automatic test_done_deferral();
    build_file(4, 2, 24, 0, 54, image_bytes(4, 2));
    send_file(1);
    send_word(8'($urandom), 1'b1, 1'b1);
    send_word(8'($urandom), 1'b0, 1'b0);
    settle();
  endtask

  task automatic test_truncation();
    write_origin(8'd126, 8'd158);
    build_file(5, 32'h8000_0001, 24, 0, 54, 20);
    send_file(1);
    settle();
  endtask

  task automatic test_random_files(input int idle, input int stall, input int budget);
    int sent, w, h, ofs, len, full, choice;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    settle();
    write_origin(pick_origin(SCREEN_W), pick_origin(SCREEN_H));
    while (sent < budget) begin
      if ($urandom_range(5) == 0) begin
        settle();
        write_origin(pick_origin(SCREEN_W), pick_origin(SCREEN_H));
      end
      w = $urandom_range(7);
      h = $urandom_range(1, 2);
      if ($urandom_range(15) == 0) w = $urandom_range(20, 60);
      if ($urandom_range(9) == 0) w = -w;
      if ($urandom_range(1)) h = -h;
      case ($urandom_range(2))
        0:       ofs = 54;
        1:       ofs = $urandom_range(53);
        default: ofs = $urandom_range(55, 70);
      endcase
      full   = image_bytes(w, h);
      choice = $urandom_range(99);
      len    = full;
      if (choice >= 60 && choice < 75) len = $urandom_range(full);
      else if (choice >= 75 && choice < 82) len = full + $urandom_range(1, 6);
      build_file(w, h, 24, 0, ofs, len);
      if (choice >= 82 && choice < 90) begin
        case ($urandom_range(3))
          0: file_bytes[$urandom_range(1)] = 8'($urandom);
          1: file_bytes[HDR_BPP0 + $urandom_range(1)] = 8'($urandom);
          2: file_bytes[HDR_CMP0 + $urandom_range(3)] = 8'($urandom_range(1, 255));
          default: file_bytes[HDR_W0 + $urandom_range(3)] = 8'($urandom);
        endcase
      end else if (choice >= 90 && choice < 95) begin
        trim_file($urandom_range(1, HEADER_BYTES));
      end
      send_file(!(choice >= 60 && choice < 75 && $urandom_range(1) == 0));
      sent += file_bytes.size();
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, 1'($urandom));
      end
      if (choice >= 95) begin
        send_word(8'($urandom), 1'b1, 1'b1);
        sent++;
      end
    end
    settle();
  endtask

  initial begin
    x_org = '0;
    y_org = '0;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_header_checks();
    test_empty_images();
    test_done_deferral();
    test_truncation();
    test_random_files(78, 0, 60);
    test_random_files(0, 78, 60);
    test_random_files(38, 38, 60);
    settle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
